// File: src/uidst_pkg.sv
// Shared types and constants for the unique ID set table.
// This package has no dependencies. The controller, the top level and the testbench use it.
package uidst_pkg;

  // Table geometry
  localparam int CAPACITY  = 256;
  localparam int ID_W      = 32;
  localparam int MODE_W    = 2;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OUT_CNT_W = 9;

  // Stream widths (payload padded to whole bytes)
  localparam int S_DATA_W = ((ID_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((OUT_CNT_W + 7) / 8) * 8;

  // Request opcodes; the fourth code is unused
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_QUERY  = 2'd2
  } mode_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_MISS,
    ST_SH_RD,
    ST_SH_WR,
    ST_DONE
  } state_t;

  // Result handed from the sequencer to the output register
  typedef struct packed {
    logic                 ok;
    logic [OUT_CNT_W-1:0] entry_count;
  } result_t;

endpackage

// File: src/uidst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// This module has no dependencies.
module uidst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wen,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: src/uidst_ctrl.sv
// Sequencer for the ID table: linear search, append and shift-down over the RAM.
// Depends on uidst_pkg. Drives one uidst_ram instance through its port signals.
module uidst_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  // request side
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [uidst_pkg::MODE_W-1:0]  req_mode,
  input  logic [uidst_pkg::ID_W-1:0]    req_id,
  // result side
  output logic                          res_valid,
  input  logic                          res_ready,
  output uidst_pkg::result_t            res,
  // RAM port
  output logic                          ram_wen,
  output logic [uidst_pkg::ADDR_W-1:0]  ram_waddr,
  output logic [uidst_pkg::ID_W-1:0]    ram_wdata,
  output logic [uidst_pkg::ADDR_W-1:0]  ram_raddr,
  input  logic [uidst_pkg::ID_W-1:0]    ram_rdata
);

  uidst_pkg::state_t state, state_next;

  logic [uidst_pkg::CNT_W-1:0]  count, count_next;
  logic [uidst_pkg::CNT_W-1:0]  idx, idx_next;
  logic [uidst_pkg::MODE_W-1:0] mode, mode_next;
  logic [uidst_pkg::ID_W-1:0]   id, id_next;
  logic                         ok, ok_next;

  logic [uidst_pkg::CNT_W-1:0]  idx_inc;
  logic                         hit;
  logic                         room;

  // Shared compare unit: RAM word against the key, count against the capacity
  assign idx_inc = uidst_pkg::CNT_W'(idx + 1'b1);
  assign hit     = (ram_rdata == id);
  assign room    = (count < uidst_pkg::CNT_W'(uidst_pkg::CAPACITY));

  // State and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uidst_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx  <= idx_next;
    mode <= mode_next;
    id   <= id_next;
    ok   <= ok_next;
  end

  // Next state and datapath control
  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    mode_next  = mode;
    id_next    = id;
    ok_next    = ok;
    req_ready  = 1'b0;
    res_valid  = 1'b0;
    ram_wen    = 1'b0;
    ram_waddr  = idx[uidst_pkg::ADDR_W-1:0];
    ram_wdata  = ram_rdata;
    ram_raddr  = idx[uidst_pkg::ADDR_W-1:0];

    case (state)
      uidst_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          mode_next = req_mode;
          id_next   = req_id;
          idx_next  = '0;
          ok_next   = 1'b0;
          if (!(req_mode inside {uidst_pkg::MODE_ADD, uidst_pkg::MODE_REMOVE,
                                 uidst_pkg::MODE_QUERY})) begin
            state_next = uidst_pkg::ST_DONE;
          end else if (count == '0) begin
            state_next = uidst_pkg::ST_MISS;
          end else begin
            state_next = uidst_pkg::ST_RD;
          end
        end
      end

      // issue read of entry idx
      uidst_pkg::ST_RD: begin
        state_next = uidst_pkg::ST_CMP;
      end

      // compare entry idx with the key
      uidst_pkg::ST_CMP: begin
        if (hit) begin
          case (mode)
            uidst_pkg::MODE_REMOVE: begin
              ok_next    = 1'b1;
              count_next = uidst_pkg::CNT_W'(count - 1'b1);
              state_next = (idx_inc < count) ? uidst_pkg::ST_SH_RD : uidst_pkg::ST_DONE;
            end
            uidst_pkg::MODE_QUERY: begin
              ok_next    = 1'b1;
              state_next = uidst_pkg::ST_DONE;
            end
            default: begin
              // add of an identifier already held
              ok_next    = 1'b0;
              state_next = uidst_pkg::ST_DONE;
            end
          endcase
        end else if (idx_inc == count) begin
          state_next = uidst_pkg::ST_MISS;
        end else begin
          idx_next   = idx_inc;
          state_next = uidst_pkg::ST_RD;
        end
      end

      // key not held: append on add when there is room
      uidst_pkg::ST_MISS: begin
        if (mode == uidst_pkg::MODE_ADD && room) begin
          ram_wen    = 1'b1;
          ram_waddr  = count[uidst_pkg::ADDR_W-1:0];
          ram_wdata  = id;
          count_next = uidst_pkg::CNT_W'(count + 1'b1);
          ok_next    = 1'b1;
        end
        state_next = uidst_pkg::ST_DONE;
      end

      // shift down: read entry idx+1
      uidst_pkg::ST_SH_RD: begin
        ram_raddr  = idx_inc[uidst_pkg::ADDR_W-1:0];
        state_next = uidst_pkg::ST_SH_WR;
      end

      // shift down: store it at idx; count already holds the reduced value
      uidst_pkg::ST_SH_WR: begin
        ram_wen    = 1'b1;
        ram_waddr  = idx[uidst_pkg::ADDR_W-1:0];
        ram_wdata  = ram_rdata;
        idx_next   = idx_inc;
        state_next = (idx_inc < count) ? uidst_pkg::ST_SH_RD : uidst_pkg::ST_DONE;
      end

      uidst_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = uidst_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = uidst_pkg::ST_IDLE;
      end
    endcase
  end

  assign res.ok          = ok;
  assign res.entry_count = uidst_pkg::OUT_CNT_W'(count);

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= uidst_pkg::CNT_W'(uidst_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (count == $past(count) || count == uidst_pkg::CNT_W'($past(count) + 1'b1) ||
              count == uidst_pkg::CNT_W'($past(count) - 1'b1)))
    else $error("entry count moved by more than one");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    (state == uidst_pkg::ST_SH_WR) |-> (idx < count))
    else $error("shift write beyond live entries");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("result dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state != uidst_pkg::ST_IDLE))
    else $error("sequencer idle right after taking a request");

endmodule

// File: src/unique_id_set_table_core.sv
// Top level of the unique ID set table: stream ports, sequencer, RAM, output register.
// Depends on uidst_pkg, uidst_ram and uidst_ctrl.
//
// Usage:
//   Requests enter on the s_ channel: s_tuser carries the opcode (add, remove,
//   query) and s_tdata the 32-bit identifier. Each request yields exactly one
//   result on the m_ channel: m_tuser is the success flag, m_tdata the entry
//   count after the operation.
//   The table keeps up to CAPACITY distinct identifiers in insertion order in one
//   RAM. The sequencer reads one entry at a time through the single read port,
//   with a read state and a compare state per entry: it searches to the match,
//   then on remove moves each later entry down with a read and a write state.
//   An unused opcode skips the search and goes straight to the result.
//   s_tready is high only while the sequencer is idle, one request at a time.
//   The result sits in an output register. A new request is taken while it waits.
//   If m_tready stays low, the next finished result holds in the sequencer.
//   A synchronous reset empties the table at once: the count goes to zero and no
//   result is pending. The RAM needs no clearing pass.
module unique_id_set_table_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [uidst_pkg::S_DATA_W-1:0]  s_tdata,  // [31:0] member_id
  input  logic [uidst_pkg::MODE_W-1:0]    s_tuser,  // [1:0] mode
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [uidst_pkg::M_DATA_W-1:0]  m_tdata,  // [8:0] entry_count, rest zero
  output logic                            m_tuser   // [0] ok
);

  logic                         res_valid;
  logic                         res_ready;
  uidst_pkg::result_t           res;
  logic                         ram_wen;
  logic [uidst_pkg::ADDR_W-1:0] ram_waddr;
  logic [uidst_pkg::ID_W-1:0]   ram_wdata;
  logic [uidst_pkg::ADDR_W-1:0] ram_raddr;
  logic [uidst_pkg::ID_W-1:0]   ram_rdata;

  // Sequencer
  uidst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req_mode  (s_tuser),
    .req_id    (s_tdata[uidst_pkg::ID_W-1:0]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_wen   (ram_wen),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Entry storage
  uidst_ram #(
    .WIDTH (uidst_pkg::ID_W),
    .DEPTH (uidst_pkg::CAPACITY),
    .AW    (uidst_pkg::ADDR_W)
  ) u_ram (
    .clk   (clk),
    .wen   (ram_wen),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= uidst_pkg::M_DATA_W'(res.entry_count);
      m_tuser <= res.ok;
    end
  end

endmodule

// File: dv/unique_id_set_table_core_test.sv
// Self-checking testbench for unique_id_set_table_core: a queue-fed stream driver,
// a predictor of the ID table, and a monitor that checks every result in order.
// Depends on uidst_pkg and the unique_id_set_table_core RTL.
module unique_id_set_table_core_test;

  // Opcode that the table must treat as a no-op
  localparam logic [uidst_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  // The limit allows for the worst-case request on each of ~1063 items, plus stalls,
  // several times over.
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int LONG_HOLD   = 600;
  localparam int POOL_SIZE   = 48;

  typedef enum {PACE_FULL, PACE_MOSTLY, PACE_SPARSE, PACE_TOGGLE} pace_t;

  // One pending request; wait_quiet marks a pause until every result is back
  typedef struct {
    bit                           wait_quiet;
    logic [uidst_pkg::MODE_W-1:0] mode;
    logic [uidst_pkg::ID_W-1:0]   id;
  } request_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [uidst_pkg::S_DATA_W-1:0] s_tdata = '0;   // [31:0] member_id
  logic [uidst_pkg::MODE_W-1:0]   s_tuser = '0;   // [1:0] mode
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [uidst_pkg::M_DATA_W-1:0] m_tdata;        // [8:0] entry_count, rest zero
  logic                           m_tuser;        // [0] ok

  request_t                   req_backlog[$];
  uidst_pkg::result_t         owed_results[$];
  logic [uidst_pkg::ID_W-1:0] held_ids[$];

  int n_errors = 0;
  int n_results = 0;
  int n_accepted = 0;
  int n_by_mode[4] = '{0, 0, 0, 0};
  int n_full_rejects = 0;
  int peak_count = 0;
  int cycle_cnt = 0;

  unique_id_set_table_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Predictor: applies one request to the table copy and returns the result
  function automatic uidst_pkg::result_t table_apply(
      input logic [uidst_pkg::MODE_W-1:0] mode,
      input logic [uidst_pkg::ID_W-1:0]   id);
    uidst_pkg::result_t r;
    int                 pos;
    r   = '0;
    pos = -1;
    for (int i = 0; i < held_ids.size() && pos < 0; i++)
      if (held_ids[i] == id) pos = i;
    case (mode)
      uidst_pkg::MODE_ADD: begin
        if (pos < 0 && held_ids.size() < uidst_pkg::CAPACITY) begin
          held_ids.push_back(id);
          r.ok = 1'b1;
        end else if (pos < 0) begin
          n_full_rejects++;
        end
      end
      uidst_pkg::MODE_REMOVE: begin
        if (pos >= 0) begin
          held_ids.delete(pos);
          r.ok = 1'b1;
        end
      end
      uidst_pkg::MODE_QUERY: r.ok = (pos >= 0);
      default: ;
    endcase
    r.entry_count = uidst_pkg::OUT_CNT_W'(held_ids.size());
    n_by_mode[mode]++;
    if (held_ids.size() > peak_count) peak_count = held_ids.size();
    return r;
  endfunction

  task automatic queue_req(input logic [uidst_pkg::MODE_W-1:0] mode,
                           input logic [uidst_pkg::ID_W-1:0] id);
    req_backlog.push_back('{1'b0, mode, id});
  endtask

  // Driver: bursts of items with random gaps, fed from req_backlog
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    request_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        owed_results.push_back(table_apply(s_tuser, s_tdata[uidst_pkg::ID_W-1:0]));
        n_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        // pause point: resume once the table has answered everything
        if (req_backlog.size() > 0 && req_backlog[0].wait_quiet && owed_results.size() == 0)
          void'(req_backlog.pop_front());
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (req_backlog.size() == 0 || req_backlog[0].wait_quiet) begin
          s_tvalid <= 1'b0;
        end else begin
          nxt = req_backlog.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= uidst_pkg::S_DATA_W'(nxt.id);
          s_tuser  <= nxt.mode;
          burst_left--;
          if (burst_left <= 0) begin
            if ($urandom_range(0, 3) == 0) begin
              burst_left = $urandom_range(20, 60);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 8);
              gap_left   = $urandom_range(1, 15);
            end
          end
        end
      end
    end
  end

  // Receiver: changing stall pattern, with a long hold-off now and then
  int    hold_left = 0;
  int    next_hold_at = 40;
  int    pace_left = 0;
  pace_t pace_mode = PACE_FULL;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (n_results >= next_hold_at) begin
      hold_left    = LONG_HOLD;
      next_hold_at = next_hold_at + 500;
      m_tready <= 1'b0;
    end else begin
      if (pace_left == 0) begin
        pace_mode = pace_t'($urandom_range(0, 3));
        pace_left = $urandom_range(20, 300);
      end
      pace_left--;
      case (pace_mode)
        PACE_FULL:   m_tready <= 1'b1;
        PACE_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
        PACE_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
        default:     m_tready <= ~m_tready;
      endcase
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    uidst_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (owed_results.size() == 0) begin
        $error("unexpected result: ok=%0b entry_count=%0d", m_tuser,
               m_tdata[uidst_pkg::OUT_CNT_W-1:0]);
        n_errors++;
      end else begin
        want = owed_results.pop_front();
        if (m_tuser !== want.ok) begin
          $error("ok: expected %0b, got %0b", want.ok, m_tuser);
          n_errors++;
        end
        if (m_tdata[uidst_pkg::OUT_CNT_W-1:0] !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count,
                 m_tdata[uidst_pkg::OUT_CNT_W-1:0]);
          n_errors++;
        end
        if ((m_tdata >> uidst_pkg::OUT_CNT_W) !== '0) begin
          $error("m_tdata padding: expected 0, got 0x%0h", m_tdata >> uidst_pkg::OUT_CNT_W);
          n_errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               owed_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    logic [uidst_pkg::ID_W-1:0] fill_ids[uidst_pkg::CAPACITY];
    logic [uidst_pkg::ID_W-1:0] id_pool[POOL_SIZE];
    logic [uidst_pkg::ID_W-1:0] tmp;
    int                         j;
    int                         r;

    // directed: empty table, duplicates, unused opcode, head/tail removal
    queue_req(uidst_pkg::MODE_QUERY,  32'h0000_0000);
    queue_req(uidst_pkg::MODE_REMOVE, 32'h0000_0000);
    queue_req(uidst_pkg::MODE_ADD,    32'h0000_0000);
    queue_req(uidst_pkg::MODE_ADD,    32'hFFFF_FFFF);
    queue_req(uidst_pkg::MODE_ADD,    32'hFFFF_FFFF);
    queue_req(uidst_pkg::MODE_ADD,    32'h0000_0000);
    queue_req(uidst_pkg::MODE_ADD,    32'h8000_0001);
    queue_req(uidst_pkg::MODE_QUERY,  32'hFFFF_FFFF);
    queue_req(uidst_pkg::MODE_QUERY,  32'h0000_0000);
    queue_req(uidst_pkg::MODE_QUERY,  32'h7FFF_FFFE);
    queue_req(MODE_UNUSED,            32'hFFFF_FFFF);
    queue_req(MODE_UNUSED,            32'h0000_0000);
    queue_req(uidst_pkg::MODE_REMOVE, 32'h0000_0000);
    queue_req(uidst_pkg::MODE_QUERY,  32'hFFFF_FFFF);
    queue_req(uidst_pkg::MODE_REMOVE, 32'h1234_5678);
    queue_req(uidst_pkg::MODE_REMOVE, 32'h8000_0001);
    queue_req(uidst_pkg::MODE_REMOVE, 32'hFFFF_FFFF);
    queue_req(uidst_pkg::MODE_REMOVE, 32'hFFFF_FFFF);
    queue_req(uidst_pkg::MODE_QUERY,  32'h8000_0001);
    req_backlog.push_back('{1'b1, MODE_UNUSED, '0});

    // fill to capacity with distinct ids (low 12 bits are the index)
    for (int i = 0; i < uidst_pkg::CAPACITY; i++) begin
      fill_ids[i] = ($urandom & 32'hFFFF_F000) | uidst_pkg::ID_W'(i);
      queue_req(uidst_pkg::MODE_ADD, fill_ids[i]);
    end
    // full table: present id, new ids, a lookup
    queue_req(uidst_pkg::MODE_ADD,   fill_ids[0]);
    queue_req(uidst_pkg::MODE_ADD,   32'h0000_0FFF | $urandom);
    queue_req(uidst_pkg::MODE_ADD,   32'h0000_0FFE | $urandom);
    queue_req(uidst_pkg::MODE_QUERY, fill_ids[uidst_pkg::CAPACITY-1]);
    // drain in shuffled order so every position gets removed
    for (int i = uidst_pkg::CAPACITY - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = fill_ids[i];
      fill_ids[i] = fill_ids[j];
      fill_ids[j] = tmp;
    end
    for (int i = 0; i < uidst_pkg::CAPACITY; i++) begin
      queue_req(uidst_pkg::MODE_REMOVE, fill_ids[i]);
      if (i % 32 == 5) queue_req(uidst_pkg::MODE_QUERY, fill_ids[i]);
    end
    req_backlog.push_back('{1'b1, MODE_UNUSED, '0});

    // random mix over a small id pool so hits are frequent
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = $urandom;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 0; i < 520; i++) begin
      r   = $urandom_range(0, 99);
      tmp = ($urandom_range(0, 9) == 0) ? $urandom : id_pool[$urandom_range(0, POOL_SIZE-1)];
      if (r < 40)      queue_req(uidst_pkg::MODE_ADD, tmp);
      else if (r < 68) queue_req(uidst_pkg::MODE_REMOVE, tmp);
      else if (r < 95) queue_req(uidst_pkg::MODE_QUERY, tmp);
      else             queue_req(MODE_UNUSED, $urandom);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (req_backlog.size() != 0 || s_tvalid || owed_results.size() != 0)
      @(posedge clk);
    repeat (2 * uidst_pkg::CAPACITY + 16) @(posedge clk);

    $display("ran %0d requests (%0d add, %0d remove, %0d query, %0d unused), %0d results",
             n_accepted, n_by_mode[uidst_pkg::MODE_ADD], n_by_mode[uidst_pkg::MODE_REMOVE],
             n_by_mode[uidst_pkg::MODE_QUERY], n_by_mode[MODE_UNUSED], n_results);
    $display("peak table size %0d of %0d, %0d adds refused on a full table",
             peak_count, uidst_pkg::CAPACITY, n_full_rejects);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
